// ===== sv/tsli_pkg.sv =====
// ----------------------------------------------------------------------------
// tsli_pkg
// Shared types and constants of the time-series linear interpolator: request
// codes, fixed-point constants and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tsli_pkg;

   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PIDX_W    = 4;
   localparam int STEP_W    = $clog2(FRAC_BITS);

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_COUNT = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [FRAC_BITS:0] ONE_Q16 = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic take;
      logic issue;
      logic check;
      logic div_step;
      logic rd1;
      logic rd2;
      logic mul;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic query;
      logic req_empty;
      logic hit;
      logic scan_end;
      logic need_div;
      logic div_done;
      logic out_free;
      logic last_param;
   } dp_status_type;

endpackage

// ===== sv/tsli_ram.sv =====
// ----------------------------------------------------------------------------
// tsli_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tsli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tsli_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsli_ctrl
// Request sequencer: row search, fraction division and per-parameter
// read/multiply/emit steps.
// ----------------------------------------------------------------------------
module tsli_ctrl
   import tsli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEEK0 = 3'd1;
   localparam logic [2:0] S_SEEK  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_RD1   = 3'd4;
   localparam logic [2:0] S_RD2   = 3'd5;
   localparam logic [2:0] S_MUL   = 3'd6;
   localparam logic [2:0] S_SUM   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && status.query) begin
               state_in = status.req_empty ? S_RD1 : S_SEEK0;
            end
         end
         S_SEEK0: begin
            cmd.issue = 1'b1;
            state_in  = S_SEEK;
         end
         S_SEEK: begin
            cmd.check = 1'b1;
            if (status.hit || status.scan_end) begin
               state_in = status.need_div ? S_DIV : S_RD1;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last_param ? S_IDLE : S_RD1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== sv/tsli_dp.sv =====
// ----------------------------------------------------------------------------
// tsli_dp
// Datapath: table store, row counts, row search compare, restoring divider
// for the fraction, two-tap multiply and the result register.
// ----------------------------------------------------------------------------
module tsli_dp
   import tsli_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 16,
   parameter int NUM_FACES   = 6,
   parameter int MAX_SPECIES = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic [PIDX_W-1:0]        nparam,
   input  logic [1:0]               req_op,
   input  logic [2:0]               req_face,
   input  logic [1:0]               req_species,
   input  logic [5:0]               req_row,
   input  logic [3:0]               req_column,
   input  logic signed [WORD_W-1:0] req_word,
   input  logic signed [WORD_W-1:0] req_query_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_value,
   output logic [PIDX_W-1:0]        rsp_param_index,
   output logic                     rsp_last,
   output logic                     rsp_empty_res
);

   localparam int TABLES = NUM_FACES * MAX_SPECIES;
   localparam int TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int DEPTH  = TABLES * MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIFF_W = WORD_W + 1;
   localparam int PROD_W = WORD_W + FRAC_BITS + 2;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [TBL_W-1:0] tb,
                                                  input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
      return ADDR_W'((ADDR_W'(tb) * ADDR_W'(MAX_ROWS) + ADDR_W'(r))
                     * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c));
   endfunction

   // request decode
   logic               req_ok;
   logic [TBL_W-1:0]   req_tbl;
   logic [CNT_W-1:0]   req_n;
   logic [CNT_W-1:0]   count_clamp;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [WORD_W-1:0]  rd_data;

   // state
   logic [CNT_W-1:0]         rc_ff [TABLES];
   logic [TBL_W-1:0]         tbl_ff, tbl_in;
   logic signed [WORD_W-1:0] t_ff, t_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic                     empty_ff, empty_in;
   logic [PIDX_W-1:0]        nparam_ff, nparam_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic signed [WORD_W-1:0] prev_ff, prev_in;
   logic [ROW_W-1:0]         i1_ff, i1_in;
   logic [ROW_W-1:0]         i2_ff, i2_in;
   logic [FRAC_BITS-1:0]     s_ff, s_in;
   logic [DIFF_W-1:0]        rem_ff, rem_in;
   logic [DIFF_W-1:0]        den_ff, den_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [PIDX_W-1:0]        j_ff, j_in;
   logic signed [WORD_W-1:0] v1_ff, v1_in;
   logic signed [PROD_W-1:0] prod1_ff, prod1_in;
   logic signed [PROD_W-1:0] prod2_ff, prod2_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [PIDX_W-1:0]        rsp_pidx_ff, rsp_pidx_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   // search and arithmetic
   logic signed [WORD_W-1:0] tcur;
   logic [CNT_W-1:0]         chk_row;
   logic                     is_last;
   logic                     hit;
   logic [DIFF_W-1:0]        diff_num;
   logic [DIFF_W-1:0]        diff_den;
   logic [DIFF_W:0]          rem_shift;
   logic                     qbit;
   logic [FRAC_BITS:0]       w1;
   logic signed [PROD_W-1:0] sum;
   logic [COL_W-1:0]         pcol;

   assign req_ok  = (int'(req_face) < NUM_FACES) && (int'(req_species) < MAX_SPECIES);
   assign req_tbl = req_ok ? TBL_W'(int'(req_face) * MAX_SPECIES + int'(req_species))
                           : '0;
   assign req_n   = req_ok ? rc_ff[req_tbl] : '0;

   always_comb begin
      if (req_word < 0) begin
         count_clamp = '0;
      end else if (req_word > MAX_ROWS) begin
         count_clamp = CNT_W'(MAX_ROWS);
      end else begin
         count_clamp = CNT_W'(req_word);
      end
   end

   assign wr_en   = cmd.take && (req_op == OP_WRITE) && req_ok
                    && (int'(req_row) < MAX_ROWS) && (int'(req_column) < MAX_COLUMNS);
   assign wr_addr = word_addr(req_tbl, ROW_W'(req_row), COL_W'(req_column));

   assign pcol = COL_W'({1'b0, j_ff} + 5'd1);

   always_comb begin
      if (cmd.rd2) begin
         rd_addr = word_addr(tbl_ff, i2_ff, pcol);
      end else if (cmd.rd1) begin
         rd_addr = word_addr(tbl_ff, i1_ff, pcol);
      end else begin
         rd_addr = word_addr(tbl_ff, scan_ff[ROW_W-1:0], '0);
      end
   end

   tsli_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign tcur      = $signed(rd_data);
   assign chk_row   = scan_ff - CNT_W'(1);
   assign is_last   = (chk_row == n_ff - CNT_W'(1));
   assign hit       = (tcur >= t_ff);
   assign diff_num  = {t_ff[WORD_W-1], t_ff} - {prev_ff[WORD_W-1], prev_ff};
   assign diff_den  = {tcur[WORD_W-1], tcur} - {prev_ff[WORD_W-1], prev_ff};
   assign rem_shift = {rem_ff, 1'b0};
   assign qbit      = (rem_shift >= {1'b0, den_ff});
   assign w1        = ONE_Q16 - {1'b0, s_ff};
   assign sum       = prod1_ff + prod2_ff;

   always_comb begin
      status            = '0;
      status.query      = (req_op == OP_QUERY);
      status.req_empty  = (req_n == '0);
      status.hit        = hit;
      status.scan_end   = !hit && is_last;
      status.need_div   = hit && (chk_row != '0) && (tcur != t_ff);
      status.div_done   = (step_ff == STEP_W'(FRAC_BITS - 1));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      status.last_param = (j_ff == nparam_ff - PIDX_W'(1));
   end

   always_comb begin
      tbl_in       = tbl_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      empty_in     = empty_ff;
      nparam_in    = nparam_ff;
      scan_in      = scan_ff;
      prev_in      = prev_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      s_in         = s_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      step_in      = step_ff;
      j_in         = j_ff;
      v1_in        = v1_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pidx_in  = rsp_pidx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;

      if (cmd.take && status.query) begin
         tbl_in    = req_tbl;
         t_in      = req_query_time;
         n_in      = req_n;
         empty_in  = status.req_empty;
         nparam_in = nparam;
         scan_in   = '0;
         i1_in     = '0;
         i2_in     = '0;
         s_in      = '0;
         j_in      = '0;
      end

      if (cmd.issue) begin
         scan_in = scan_ff + CNT_W'(1);
      end

      if (cmd.check) begin
         prev_in = tcur;
         if (hit) begin
            i2_in = chk_row[ROW_W-1:0];
            if (chk_row == '0 || tcur == t_ff) begin
               i1_in = chk_row[ROW_W-1:0];
            end else begin
               i1_in   = ROW_W'(chk_row - CNT_W'(1));
               rem_in  = diff_num;
               den_in  = diff_den;
               step_in = '0;
            end
         end else if (is_last) begin
            i1_in = chk_row[ROW_W-1:0];
            i2_in = chk_row[ROW_W-1:0];
         end
      end

      if (cmd.div_step) begin
         rem_in  = qbit ? DIFF_W'(rem_shift - {1'b0, den_ff}) : DIFF_W'(rem_shift);
         s_in    = {s_ff[FRAC_BITS-2:0], qbit};
         step_in = step_ff + STEP_W'(1);
      end

      if (cmd.rd2) begin
         v1_in = $signed(rd_data);
      end

      if (cmd.mul) begin
         prod1_in = v1_ff * $signed({1'b0, w1});
         prod2_in = $signed(rd_data) * $signed({2'b0, s_ff});
      end

      if (cmd.emit) begin
         rsp_value_in = empty_ff ? '0 : sum[WORD_W+FRAC_BITS-1:FRAC_BITS];
         rsp_pidx_in  = j_ff;
         rsp_last_in  = status.last_param;
         rsp_empty_in = empty_ff;
         j_in         = j_ff + PIDX_W'(1);
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLES; i++) begin
            rc_ff[i] <= '0;
         end
      end else if (cmd.take && (req_op == OP_COUNT) && req_ok) begin
         rc_ff[req_tbl] <= count_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff       <= tbl_in;
      t_ff         <= t_in;
      n_ff         <= n_in;
      empty_ff     <= empty_in;
      nparam_ff    <= nparam_in;
      scan_ff      <= scan_in;
      prev_ff      <= prev_in;
      i1_ff        <= i1_in;
      i2_ff        <= i2_in;
      s_ff         <= s_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      step_ff      <= step_in;
      j_ff         <= j_in;
      v1_ff        <= v1_in;
      prod1_ff     <= prod1_in;
      prod2_ff     <= prod2_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pidx_ff  <= rsp_pidx_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_param_index = rsp_pidx_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_empty_res   = rsp_empty_ff;

endmodule

// ===== sv/time_series_linear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// time_series_linear_interpolator_unit
// Piecewise-linear interpolation over per-face, per-species time tables.
//
// Requests enter on req_* (valid/stall) and carry one of three operations:
// a table word write, a row count set, or a time query. Writes and row count
// sets finish in the cycle they are accepted and give no response. A query
// answers with one response on rsp_* per parameter column (columns_in_use - 1
// of them, columns_in_use taken as clamped to 2..MAX_COLUMNS), the final one
// flagged by rsp_last; an empty table answers zeros with rsp_empty_res set.
// A query runs a row search (one table read a cycle over the rows scanned), a
// division for the 16-bit fraction when it lands between two rows, and per
// parameter column two table reads on the single read port, a multiply stage
// and the result register. The next request is taken the cycle after the last
// response enters the output register.
// While rsp_stall is high with a response held, the result register holds
// and the sequencer waits at its next emit.
// Reset clears all row counts (tables read as empty) and sets columns_in_use
// to 2; table words are undefined until written. columns_in_use sits at
// byte address 0 of the csr_* port.
// ----------------------------------------------------------------------------
module time_series_linear_interpolator_unit
   import tsli_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 16,
   parameter int NUM_FACES   = 6,
   parameter int MAX_SPECIES = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [2:0]               req_face,
   input  logic [1:0]               req_species,
   input  logic [5:0]               req_row,
   input  logic [3:0]               req_column,
   input  logic signed [WORD_W-1:0] req_word,
   input  logic signed [WORD_W-1:0] req_query_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_value,
   output logic [PIDX_W-1:0]        rsp_param_index,
   output logic                     rsp_last,
   output logic                     rsp_empty_res,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [4:0]        cols_ff;
   logic [4:0]        cols_in;
   logic [4:0]        cols_eff;
   logic [PIDX_W-1:0] nparam;
   dp_cmd_type        cmd;
   dp_status_type     status;

   always_comb begin
      cols_in = cols_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         cols_in = csr_pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 5'd2;
      end else begin
         cols_ff <= cols_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {27'd0, cols_ff};

   always_comb begin
      if (cols_ff < 5'd2) begin
         cols_eff = 5'd2;
      end else if (int'(cols_ff) > MAX_COLUMNS) begin
         cols_eff = 5'(MAX_COLUMNS);
      end else begin
         cols_eff = cols_ff;
      end
   end

   assign nparam = PIDX_W'(cols_eff - 5'd1);

   tsli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tsli_dp #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .NUM_FACES   (NUM_FACES),
      .MAX_SPECIES (MAX_SPECIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .nparam          (nparam),
      .req_op          (req_op),
      .req_face        (req_face),
      .req_species     (req_species),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_word        (req_word),
      .req_query_time  (req_query_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_param_index (rsp_param_index),
      .rsp_last        (rsp_last),
      .rsp_empty_res   (rsp_empty_res)
   );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for time_series_linear_interpolator_unit. Loads time
// tables through write and row count requests, queries them at exact, inner,
// outer and extreme times, and checks every response against a predictor that
// tracks the tables, the row counts and columns_in_use. Requests get idle gaps,
// responses get stalls, and columns_in_use is swept between traffic phases.
// ----------------------------------------------------------------------------
module tb_top
   import tsli_pkg::*;
();

   localparam int ROWS_PER_TABLE = 64;
   localparam int COLS_PER_ROW   = 16;
   localparam int FACES          = 6;
   localparam int SPECIES        = 4;
   localparam int TABLES         = FACES * SPECIES;
   localparam int STORE_WORDS    = TABLES * ROWS_PER_TABLE * COLS_PER_ROW;
   localparam logic [1:0] OP_IGNORED  = 2'd3;
   localparam logic [2:0] CSR_COLUMNS = 3'd0;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef logic signed [WORD_W-1:0] q16_type;

   typedef struct {
      logic [1:0] op;
      logic [2:0] face;
      logic [1:0] species;
      logic [5:0] row;
      logic [3:0] column;
      q16_type    word;
      q16_type    query_time;
   } request_type;

   typedef struct {
      q16_type           value;
      logic [PIDX_W-1:0] param_index;
      logic              last;
      logic              empty_res;
   } response_type;

   class interp_tracker;
      bit [31:0]    store [STORE_WORDS];
      bit           written [STORE_WORDS];
      int           rows [TABLES];
      bit [4:0]     columns_cfg;
      response_type values_due [$];
      int           mismatches;

      function void clear();
         foreach (written[i]) written[i] = 1'b0;
         foreach (rows[i]) rows[i] = 0;
         columns_cfg = 5'd2;
         mismatches = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function int pending();
         return values_due.size();
      endfunction

      function int active_columns();
         if (columns_cfg < 2) return 2;
         if (columns_cfg > COLS_PER_ROW) return COLS_PER_ROW;
         return columns_cfg;
      endfunction

      function int table_of(request_type q);
         if (q.face >= FACES) return -1;
         return q.face * SPECIES + q.species;
      endfunction

      function int addr(int tbl, int r, int c);
         return (tbl * ROWS_PER_TABLE + r) * COLS_PER_ROW + c;
      endfunction

      function longint word_of(int tbl, int r, int c);
         return longint'($signed(store[addr(tbl, r, c)]));
      endfunction

      // works out the responses of a query; returns 0 if it would read a word never written
      function bit interpolate(request_type q, bit commit);
         int tbl, n, nparam, i1, i2, j, k;
         bit empty, safe, found;
         longint t, t1, t2, frac, acc;
         longint unsigned num, den;
         response_type a;
         tbl = table_of(q);
         n = (tbl >= 0) ? rows[tbl] : 0;
         empty = (n == 0);
         nparam = active_columns() - 1;
         t = longint'(q.query_time);
         i1 = 0;
         i2 = 0;
         frac = 0;
         safe = 1'b1;
         found = 1'b0;
         if (!empty) begin
            safe &= written[addr(tbl, 0, 0)];
            if (t >= word_of(tbl, 0, 0)) begin
               for (k = 0; k < n && !found; k++) begin
                  safe &= written[addr(tbl, k, 0)];
                  if (word_of(tbl, k, 0) >= t) begin
                     found = 1'b1;
                     i2 = k;
                  end
               end
               if (!found) begin
                  i1 = n - 1;
                  i2 = n - 1;
               end else if (i2 > 0) begin
                  t1 = word_of(tbl, i2 - 1, 0);
                  t2 = word_of(tbl, i2, 0);
                  if (t2 == t) begin
                     i1 = i2;
                  end else begin
                     num = longint'(t - t1) << 16;
                     den = t2 - t1;
                     i1 = i2 - 1;
                     frac = longint'((num / den) & 64'hFFFF);
                  end
               end
            end
            for (j = 0; j < nparam; j++) begin
               safe &= written[addr(tbl, i1, j + 1)] & written[addr(tbl, i2, j + 1)];
            end
         end
         if (commit) begin
            for (j = 0; j < nparam; j++) begin
               acc = 0;
               if (!empty) begin
                  acc = (word_of(tbl, i1, j + 1) * (65536 - frac)
                         + word_of(tbl, i2, j + 1) * frac) >>> 16;
               end
               a.value = acc[31:0];
               a.param_index = j[PIDX_W-1:0];
               a.last = (j == nparam - 1);
               a.empty_res = empty;
               values_due.insert(values_due.size(), a);
            end
         end
         return safe;
      endfunction

      function void take_request(request_type q);
         int tbl;
         tbl = table_of(q);
         case (q.op)
            OP_WRITE: if (tbl >= 0) begin
               store[addr(tbl, q.row, q.column)] = q.word;
               written[addr(tbl, q.row, q.column)] = 1'b1;
            end
            OP_COUNT: if (tbl >= 0) begin
               if (q.word < 0) rows[tbl] = 0;
               else if (q.word > ROWS_PER_TABLE) rows[tbl] = ROWS_PER_TABLE;
               else rows[tbl] = q.word;
            end
            OP_QUERY: void'(interpolate(q, 1'b1));
            default: ;
         endcase
      endfunction

      function void match_response(response_type got);
         response_type want;
         string        exp_text;
         if (values_due.size() == 0) begin
            flag($sformatf("unexpected response: value %h index %0d last %b empty %b",
                           got.value, got.param_index, got.last, got.empty_res));
            return;
         end
         want = values_due.pop_front();
         if (got.value !== want.value || got.param_index !== want.param_index ||
             got.last !== want.last || got.empty_res !== want.empty_res) begin
            exp_text = $sformatf("expected value %h index %0d last %b empty %b",
                                 want.value, want.param_index, want.last, want.empty_res);
            flag($sformatf("response mismatch: %s, got value %h index %0d last %b empty %b",
                           exp_text, got.value, got.param_index, got.last, got.empty_res));
         end
      endfunction
   endclass

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_op = '0;
   logic [2:0]        req_face = '0;
   logic [1:0]        req_species = '0;
   logic [5:0]        req_row = '0;
   logic [3:0]        req_column = '0;
   q16_type           req_word = '0;
   q16_type           req_query_time = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   q16_type           rsp_value;
   logic [PIDX_W-1:0] rsp_param_index;
   logic              rsp_last;
   logic              rsp_empty_res;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   interp_tracker sb;
   response_type  rsp_seen;
   int            items_sent = 0;
   int            sender_idle_pct = 22;
   int            stall_pct = 62;
   int            loaded_tables [$];
   int            cfg_plan [7] = '{16, 0, 31, 2, 9, 1, 17};

   time_series_linear_interpolator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_face        (req_face),
      .req_species     (req_species),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_word        (req_word),
      .req_query_time  (req_query_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_param_index (rsp_param_index),
      .rsp_last        (rsp_last),
      .rsp_empty_res   (rsp_empty_res),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen.value = rsp_value;
         rsp_seen.param_index = rsp_param_index;
         rsp_seen.last = rsp_last;
         rsp_seen.empty_res = rsp_empty_res;
         sb.match_response(rsp_seen);
      end
   end

   function automatic request_type noise_req();
      request_type q;
      q.op = 2'($urandom);
      q.face = 3'($urandom);
      q.species = 2'($urandom);
      q.row = 6'($urandom);
      q.column = 4'($urandom);
      q.word = $urandom;
      q.query_time = $urandom;
      return q;
   endfunction

   task automatic send(input request_type q);
      int gap;
      req_valid <= 1'b1;
      req_op <= q.op;
      req_face <= q.face;
      req_species <= q.species;
      req_row <= q.row;
      req_column <= q.column;
      req_word <= q.word;
      req_query_time <= q.query_time;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_request(q);
      if (q.op != OP_IGNORED) items_sent++;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put_word(input int face, input int species, input int r, input int c,
                           input q16_type value);
      request_type q;
      q = noise_req();
      q.op = OP_WRITE;
      q.face = 3'(face);
      q.species = 2'(species);
      q.row = 6'(r);
      q.column = 4'(c);
      q.word = value;
      send(q);
   endtask

   task automatic put_rows(input int face, input int species, input q16_type count);
      request_type q;
      q = noise_req();
      q.op = OP_COUNT;
      q.face = 3'(face);
      q.species = 2'(species);
      q.word = count;
      send(q);
   endtask

   task automatic ask(input int face, input int species, input q16_type t);
      request_type q;
      q = noise_req();
      q.op = OP_QUERY;
      q.face = 3'(face);
      q.species = 2'(species);
      q.query_time = t;
      send(q);
   endtask

   // no request in flight and every response back
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [2:0] where,
                             input logic [31:0] data, output logic [31:0] rd);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= where;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_columns(input logic [4:0] value);
      logic [31:0] rd;
      settle();
      csr_access(1'b1, CSR_COLUMNS, {27'd0, value}, rd);
      sb.columns_cfg = value;
      csr_access(1'b0, CSR_COLUMNS, 32'd0, rd);
      if (rd[4:0] !== value) begin
         sb.flag($sformatf("columns_in_use readback: expected %0d, got %0d", value, rd[4:0]));
      end
   endtask

   task automatic load_table(input int face, input int species, input int n);
      int r, c, cols;
      q16_type tv, v;
      bit scramble;
      cols = sb.active_columns();
      scramble = ($urandom_range(9) == 0);
      tv = q16_type'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000;
      for (r = 0; r < n; r++) begin
         if (scramble) tv = $urandom;
         else if (r > 0) tv = tv + q16_type'($urandom_range(1, 1 << $urandom_range(0, 24)));
         for (c = 0; c < cols; c++) begin
            v = $urandom;
            if (c == 0) v = tv;
            else if ($urandom_range(4) == 0) v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            put_word(face, species, r, c, v);
         end
      end
      put_rows(face, species, ($urandom_range(3) == 0) ? $urandom_range(1, n) : n);
      loaded_tables.insert(loaded_tables.size(), face * SPECIES + species);
      if (loaded_tables.size() > 12) void'(loaded_tables.pop_front());
   endtask

   function automatic q16_type pick_time(input int tbl);
      int n, k;
      longint t;
      n = (tbl >= 0) ? sb.rows[tbl] : 0;
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: ;
      endcase
      if (n == 0) return $urandom;
      k = $urandom_range(n - 1);
      if (!sb.written[sb.addr(tbl, k, 0)]) return $urandom;
      t = sb.word_of(tbl, k, 0);
      case ($urandom_range(2))
         0: ;
         1: t = t - longint'($urandom_range(1, 1 << $urandom_range(0, 22)));
         default: t = t + longint'($urandom_range(1, 1 << $urandom_range(0, 22)));
      endcase
      if (t > Q_MAX) t = Q_MAX;
      if (t < Q_MIN) t = Q_MIN;
      return t[31:0];
   endfunction

   task automatic random_query();
      request_type q;
      int tbl;
      q = noise_req();
      q.op = OP_QUERY;
      if (loaded_tables.size() > 0 && $urandom_range(9) < 8) begin
         tbl = loaded_tables[$urandom_range(loaded_tables.size() - 1)];
         q.face = 3'(tbl / SPECIES);
         q.species = 2'(tbl % SPECIES);
      end
      q.query_time = pick_time(sb.table_of(q));
      // steer away from words never written: an absent face answers as empty
      if (!sb.interpolate(q, 1'b0)) q.face = 3'(FACES + $urandom_range(1));
      send(q);
   endtask

   task automatic random_traffic(input int budget);
      int stop, pick, n;
      request_type q;
      stop = items_sent + budget;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            n = $urandom_range(1, 5);
            if ($urandom_range(9) == 0 && sb.active_columns() <= 4) n = $urandom_range(6, 12);
            load_table($urandom_range(FACES - 1), $urandom_range(SPECIES - 1), n);
         end else if (pick < 75) begin
            random_query();
         end else if (pick < 85) begin
            q = noise_req();
            q.op = OP_COUNT;
            case ($urandom_range(3))
               0: q.word = 0 - int'($urandom_range(1, 100));
               1: q.word = $urandom_range(0, 80);
               2: q.word = 32'sh7FFF_FFFF;
               default: ;
            endcase
            send(q);
         end else if (pick < 95) begin
            q = noise_req();
            q.op = OP_WRITE;
            send(q);
         end else if (pick < 98) begin
            q = noise_req();
            q.op = OP_IGNORED;
            send(q);
         end else begin
            settle();
         end
      end
   endtask

   initial begin
      request_type q;
      int seg;
      sb = new();
      sb.clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table after reset
      ask(0, 0, $urandom);
      // full-scale times and values on the highest face and species
      put_word(5, 3, 0, 0, 32'sh8000_0000);
      put_word(5, 3, 0, 1, 32'sh7FFF_FFFF);
      put_word(5, 3, 1, 0, 32'sh7FFF_FFFF);
      put_word(5, 3, 1, 1, 32'sh8000_0000);
      put_rows(5, 3, 2);
      ask(5, 3, 32'sh8000_0000);
      ask(5, 3, 0);
      ask(5, 3, 32'sh7FFF_FFFF);
      put_word(0, 0, 0, 0, 32'sh0001_0000);
      put_word(0, 0, 0, 1, 32'sh0002_8000);
      put_word(0, 0, 1, 0, 32'sh0003_0000);
      put_word(0, 0, 1, 1, -32'sh0001_4000);
      put_rows(0, 0, 2);
      ask(0, 0, -5);
      ask(0, 0, 32'sh0002_0000);
      ask(0, 0, 32'sh0005_0000);
      // negative row count clamps to empty, oversized count clamps to the maximum
      put_rows(1, 2, -5);
      ask(1, 2, 0);
      put_rows(5, 3, 1000);
      ask(5, 3, 32'sh8000_0000);
      put_rows(5, 3, 2);
      // absent face and an unused op code
      ask(6, 1, 0);
      put_word(7, 0, 0, 0, $urandom);
      q = noise_req();
      q.op = OP_IGNORED;
      send(q);
      loaded_tables.insert(loaded_tables.size(), 0);
      loaded_tables.insert(loaded_tables.size(), TABLES - 1);

      for (seg = 0; seg < 7; seg++) begin
         sender_idle_pct = (seg < 2) ? 22 : ((seg < 4) ? 62 : 0);
         stall_pct = (seg < 2) ? 62 : ((seg < 4) ? 22 : 0);
         set_columns(5'(cfg_plan[seg]));
         random_traffic(14);
      end

      settle();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
